/* hdl/fisr_pkg.sv */
`default_nettype none
package fisr_pkg;

   localparam logic [31:0] MAGIC_GUESS     = 32'h5f3759df;
   localparam logic [31:0] CANON_NAN       = 32'h7fc00000;
   localparam logic [31:0] FP_HALF         = 32'h3f000000;
   localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
   localparam int          OP_COUNT        = 9;

   typedef enum logic [1:0] {SPEC_NONE, SPEC_ZERO, SPEC_INF, SPEC_NAN} spec_type;
   typedef enum logic {OP_MUL, OP_SUB} op_kind_type;
   typedef enum logic [1:0] {SRC_H, SRC_Y, SRC_T, SRC_CONST} src_type;
   typedef enum logic [1:0] {DST_H, DST_T, DST_Y, DST_Y_FIRST} dst_type;

   typedef struct packed {
      op_kind_type kind;
      src_type     src_a;
      src_type     src_b;
      dst_type     dst;
      logic [31:0] k;
   } op_desc_type;

   // half_n, then two rounds of t1 = h*y, t2 = t1*y, t3 = 1.5 - t2, y = y*t3
   localparam op_desc_type OP_TABLE [OP_COUNT] = '{
      '{OP_MUL, SRC_H,     SRC_CONST, DST_H,       FP_HALF},
      '{OP_MUL, SRC_H,     SRC_Y,     DST_T,       32'd0},
      '{OP_MUL, SRC_T,     SRC_Y,     DST_T,       32'd0},
      '{OP_SUB, SRC_CONST, SRC_T,     DST_T,       FP_THREE_HALVES},
      '{OP_MUL, SRC_Y,     SRC_T,     DST_Y_FIRST, 32'd0},
      '{OP_MUL, SRC_H,     SRC_Y,     DST_T,       32'd0},
      '{OP_MUL, SRC_T,     SRC_Y,     DST_T,       32'd0},
      '{OP_SUB, SRC_CONST, SRC_T,     DST_T,       FP_THREE_HALVES},
      '{OP_MUL, SRC_Y,     SRC_T,     DST_Y,       32'd0}
   };

   typedef struct packed {
      logic        two;
      logic [31:0] h;
      logic [31:0] y;
      logic [31:0] t;
      logic [31:0] first;
   } side_type;

   typedef struct packed {
      logic        sign;
      logic [7:0]  e;
      logic [23:0] m;
      logic        nan;
      logic        inf;
      logic        zero;
   } unp_type;

   typedef struct packed {
      logic               sign;
      spec_type           spec;
      logic signed [10:0] e;
      logic [47:0]        p;
   } mul_mid_type;

   typedef struct packed {
      logic               sign;
      spec_type           spec;
      logic               sub;
      logic signed [10:0] e;
      logic [26:0]        big;
      logic [26:0]        lesser;
   } add_mid_type;

   typedef struct packed {
      logic               sign;
      spec_type           spec;
      logic signed [10:0] base;
      logic [23:0]        mant;
      logic               g;
      logic               st;
   } round_type;

   typedef struct packed {
      logic        valid;
      side_type    side;
      mul_mid_type mm;
      add_mid_type am;
   } st_a_type;

   typedef struct packed {
      logic      valid;
      side_type  side;
      round_type rnd;
   } st_b_type;

   typedef struct packed {
      logic     valid;
      side_type side;
   } st_c_type;

   function automatic logic [31:0] pick(input side_type s, input src_type src,
                                        input logic [31:0] k);
      logic [31:0] r;
      unique case (src)
         SRC_H:     r = s.h;
         SRC_Y:     r = s.y;
         SRC_T:     r = s.t;
         SRC_CONST: r = k;
      endcase
      return r;
   endfunction

   function automatic unp_type unpack(input logic [31:0] x);
      unp_type u;
      u.sign = x[31];
      u.e    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      u.m    = {x[30:23] != 8'd0, x[22:0]};
      u.nan  = (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
      u.inf  = (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
      u.zero = (x[30:0] == 31'd0);
      return u;
   endfunction

   function automatic mul_mid_type mul_a(input logic [31:0] a, input logic [31:0] b);
      unp_type     ua;
      unp_type     ub;
      mul_mid_type r;
      ua     = unpack(a);
      ub     = unpack(b);
      r.sign = ua.sign ^ ub.sign;
      if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
         r.spec = SPEC_NAN;
      end else if (ua.inf || ub.inf) begin
         r.spec = SPEC_INF;
      end else if (ua.zero || ub.zero) begin
         r.spec = SPEC_ZERO;
      end else begin
         r.spec = SPEC_NONE;
      end
      r.e = $signed({3'b000, ua.e}) + $signed({3'b000, ub.e}) - 11'sd127;
      r.p = 48'(ua.m) * 48'(ub.m);
      return r;
   endfunction

   function automatic round_type mul_b(input mul_mid_type m);
      round_type          r;
      logic [5:0]         lead;
      logic [5:0]         lsh;
      logic signed [10:0] er;
      logic signed [10:0] rsh;
      logic [47:0]        nl;
      logic [47:0]        nr;
      logic [47:0]        mask;
      lead = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (m.p[i]) lead = 6'(i);
      end
      lsh    = 6'd47 - lead;
      nl     = m.p << lsh;
      er     = m.e + $signed({5'd0, lead}) - 11'sd46;
      r.sign = m.sign;
      r.spec = m.spec;
      if (er >= 11'sd1) begin
         r.base = er - 11'sd1;
         r.mant = nl[47:24];
         r.g    = nl[23];
         r.st   = |nl[22:0];
      end else begin
         rsh = 11'sd1 - er;
         if (rsh >= 11'sd48) begin
            nr   = 48'd0;
            mask = '1;
         end else begin
            nr   = nl >> rsh[5:0];
            mask = (48'd1 << rsh[5:0]) - 48'd1;
         end
         r.base = 11'sd0;
         r.mant = nr[47:24];
         r.g    = nr[23];
         r.st   = (|nr[22:0]) | (|(nl & mask));
      end
      return r;
   endfunction

   function automatic add_mid_type add_a(input logic [31:0] a, input logic [31:0] b);
      unp_type     ua;
      unp_type     ub;
      unp_type     ubig;
      unp_type     ulit;
      add_mid_type r;
      logic [7:0]  d;
      logic [26:0] lit;
      logic [26:0] mask;
      ua = unpack(a);
      ub = unpack(b);
      if ({ua.e, ua.m} >= {ub.e, ub.m}) begin
         ubig = ua;
         ulit = ub;
      end else begin
         ubig = ub;
         ulit = ua;
      end
      r.sign = ubig.sign;
      r.sub  = ua.sign ^ ub.sign;
      if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != ub.sign))) begin
         r.spec = SPEC_NAN;
      end else if (ua.inf) begin
         r.spec = SPEC_INF;
         r.sign = ua.sign;
      end else if (ub.inf) begin
         r.spec = SPEC_INF;
         r.sign = ub.sign;
      end else begin
         r.spec = SPEC_NONE;
      end
      d     = ubig.e - ulit.e;
      r.e   = $signed({3'b000, ubig.e});
      r.big = {ubig.m, 3'b000};
      lit   = {ulit.m, 3'b000};
      if (d >= 8'd27) begin
         r.lesser = {26'd0, |lit};
      end else begin
         mask     = (27'd1 << d[4:0]) - 27'd1;
         r.lesser = (lit >> d[4:0]) | {26'd0, |(lit & mask)};
      end
      return r;
   endfunction

   function automatic round_type add_b(input add_mid_type m);
      round_type          r;
      logic [27:0]        sum;
      logic [26:0]        n;
      logic [4:0]         lead;
      logic [4:0]         lz;
      logic [4:0]         sh;
      logic signed [10:0] e;
      sum = m.sub ? ({1'b0, m.big} - {1'b0, m.lesser}) : ({1'b0, m.big} + {1'b0, m.lesser});
      r.sign = m.sign;
      r.spec = m.spec;
      lead   = 5'd0;
      for (int i = 0; i < 27; i++) begin
         if (sum[i]) lead = 5'(i);
      end
      lz = 5'd26 - lead;
      sh = lz;
      if (sum[27]) begin
         n = sum[27:1] | {26'd0, sum[0]};
         e = m.e + 11'sd1;
      end else begin
         if ((m.e - 11'sd1) < $signed({6'd0, lz})) sh = 5'(m.e - 11'sd1);
         n = sum[26:0] << sh;
         e = m.e - $signed({6'd0, sh});
      end
      if ((m.spec == SPEC_NONE) && (sum == 28'd0)) begin
         r.spec = SPEC_ZERO;
         if (m.sub) r.sign = 1'b0;
      end
      r.base = e - 11'sd1;
      r.mant = n[26:3];
      r.g    = n[2];
      r.st   = |n[1:0];
      return r;
   endfunction

   function automatic logic [31:0] round_pack(input round_type r);
      logic               inc;
      logic [24:0]        m25;
      logic signed [11:0] ex;
      logic [31:0]        res;
      inc = r.g && (r.st || r.mant[0]);
      m25 = {1'b0, r.mant} + {24'd0, inc};
      ex  = {r.base[10], r.base} + $signed({10'd0, m25[24:23]});
      unique case (r.spec)
         SPEC_NAN:  res = CANON_NAN;
         SPEC_INF:  res = {r.sign, 8'hff, 23'd0};
         SPEC_ZERO: res = {r.sign, 31'd0};
         SPEC_NONE: begin
            if (ex >= 12'sd255) res = {r.sign, 8'hff, 23'd0};
            else                res = {r.sign, ex[7:0], m25[22:0]};
         end
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

/* hdl/fast_inverse_sqrt_unit.sv */
`default_nettype none
// Fast reciprocal square root on single-precision words: initial guess from
// 0x5f3759df minus the input bits shifted right by one, then one or two Newton
// steps (csr_wdata sets the count: 0/1 give one, 2/3 give two) in IEEE single
// precision with round-to-nearest-even, subnormals kept, NaNs returned as
// 0x7fc00000. One word is accepted per cycle while the result side is not
// stalled; each word passes nine chained float operations of three register
// stages each. Both steps always run; the count only picks which estimate is
// returned. A stall on the result side holds the whole pipeline.
module fast_inverse_sqrt_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value_bits
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [31:0] result_bits
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_wdata
);
   import fisr_pkg::*;

   logic [1:0]  steps_ff;
   logic        en;
   side_type    entry;
   st_c_type    src   [OP_COUNT];
   logic [31:0] opa   [OP_COUNT];
   logic [31:0] opb   [OP_COUNT];
   logic [31:0] res   [OP_COUNT];
   st_a_type    a_in  [OP_COUNT];
   st_a_type    a_ff  [OP_COUNT];
   st_b_type    b_in  [OP_COUNT];
   st_b_type    b_ff  [OP_COUNT];
   st_c_type    c_in  [OP_COUNT];
   st_c_type    c_ff  [OP_COUNT];

   assign en         = !c_ff[OP_COUNT-1].valid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = c_ff[OP_COUNT-1].valid;
   assign rsp_tdata  = c_ff[OP_COUNT-1].side.two ? c_ff[OP_COUNT-1].side.y
                                                 : c_ff[OP_COUNT-1].side.first;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= 2'd1;
      end else if (csr_wen) begin
         steps_ff <= csr_wdata;
      end
   end

   always_comb begin
      entry.two   = steps_ff[1];
      entry.h     = req_tdata;
      entry.y     = MAGIC_GUESS - {req_tdata[31], req_tdata[31:1]};
      entry.t     = 32'd0;
      entry.first = 32'd0;
      src[0].valid = req_tvalid;
      src[0].side  = entry;
      for (int i = 1; i < OP_COUNT; i++) src[i] = c_ff[i-1];
      for (int i = 0; i < OP_COUNT; i++) begin
         opa[i] = pick(src[i].side, OP_TABLE[i].src_a, OP_TABLE[i].k);
         opb[i] = pick(src[i].side, OP_TABLE[i].src_b, OP_TABLE[i].k);
         a_in[i].valid = src[i].valid;
         a_in[i].side  = src[i].side;
         a_in[i].mm    = mul_a(opa[i], opb[i]);
         a_in[i].am    = add_a(opa[i], {~opb[i][31], opb[i][30:0]});

         b_in[i].valid = a_ff[i].valid;
         b_in[i].side  = a_ff[i].side;
         b_in[i].rnd   = (OP_TABLE[i].kind == OP_MUL) ? mul_b(a_ff[i].mm)
                                                      : add_b(a_ff[i].am);

         res[i]        = round_pack(b_ff[i].rnd);
         c_in[i].valid = b_ff[i].valid;
         c_in[i].side  = b_ff[i].side;
         unique case (OP_TABLE[i].dst)
            DST_H: c_in[i].side.h = res[i];
            DST_T: c_in[i].side.t = res[i];
            DST_Y: c_in[i].side.y = res[i];
            DST_Y_FIRST: begin
               c_in[i].side.y     = res[i];
               c_in[i].side.first = res[i];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OP_COUNT; i++) begin
            a_ff[i].valid <= 1'b0;
            b_ff[i].valid <= 1'b0;
            c_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (c_ff[OP_COUNT-1].valid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");

   a_nan_canonical: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[30:23] == 8'hff) && (rsp_tdata[22:0] != 23'd0))
      |-> (rsp_tdata == CANON_NAN))
      else $error("non-canonical NaN on result");

   a_valid_moves: assert property (@(posedge clock) disable iff (reset)
      en |=> (b_ff[0].valid == $past(a_ff[0].valid)))
      else $error("valid lost between stages");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(b_ff[4]))
      else $error("mid pipeline changed during stall");

endmodule
`default_nettype wire
